### hw/rtl/binned_id_table_remove_macros.svh
// Assertion macros for the binned id table checker.
// Needs a signal named clock and one named reset in the scope of use.
`ifndef BINNED_ID_TABLE_REMOVE_MACROS_SVH
`define BINNED_ID_TABLE_REMOVE_MACROS_SVH

// Same-cycle implication, off during reset.
`define BITR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define BITR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks across reset.
`define BITR_ASSERT_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/bitr_pkg.sv
// Shared types and constants of the binned id table remove block.
// No dependencies.
package bitr_pkg;

   localparam int ID_SLOTS  = 65536;
   localparam int BIN_COUNT = 4096;
   localparam int MAX_READS = 1048576;

   localparam int OP_W    = 2;
   localparam int BIN_W   = 13;
   localparam int SLOT_W  = 16;
   localparam int WORD_W  = 21;
   localparam int KEY_W   = 20;
   localparam int START_W = 17;
   localparam int FLAG_AW = 12;
   localparam int POS_W   = 24;

   localparam logic [OP_W-1:0] OP_LOAD_START = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_SLOT  = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND       = 2'd2;
   localparam logic [OP_W-1:0] OP_REMOVE     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [BIN_W-1:0]  bin_index;
      logic [SLOT_W-1:0] slot_address;
      logic [WORD_W-1:0] load_value;
      logic [KEY_W-1:0]  remove_id;
   } req_data_type;

   typedef struct packed {
      logic [START_W-1:0] range_begin;
      logic [START_W-1:0] range_end;
      logic               bin_empty;
   } rsp_data_type;

endpackage

### hw/rtl/bitr_req_if.sv
// Request channel of the binned id table: valid, ready and one item.
// Depends on bitr_pkg.
interface bitr_req_if;
   logic                  valid;
   logic                  ready;
   bitr_pkg::req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/bitr_rsp_if.sv
// Response channel of the binned id table: valid, ready and one item.
// Depends on bitr_pkg.
interface bitr_rsp_if;
   logic                  valid;
   logic                  ready;
   bitr_pkg::rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/binned_id_table_remove.sv
// Binned read-id table with find and remove, one sequencer over one id memory.
// Depends on bitr_pkg, bitr_req_if, bitr_rsp_if.
//
//  channel   dir  item
//  req_chan  in   opcode, bin_index, slot_address, load_value, remove_id
//  rsp_chan  out  range_begin, range_end, bin_empty
//
// Load ops and out-of-range bins: result one cycle after accept.
// Find: two start table reads, then two marker reads, plus output wait.
// Remove: as find, then bisection steps (probe read, compare), shift steps (read,
// write per entry), a marker reread and write, and a second write when the size
// marker is written; a one-entry bin is only flagged empty. Req waits for idle.
// After reset all 4096 empty flags are cleared, one entry a cycle, with req not
// ready. A waiting result holds off the next item and the final state.
module binned_id_table_remove (
   input  logic            clock,
   input  logic            reset,
   bitr_req_if.sink        req_chan,
   bitr_rsp_if.source      rsp_chan
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_FIRST = 4'd2;
   localparam logic [3:0] S_LIMIT = 4'd3;
   localparam logic [3:0] S_RM1   = 4'd4;
   localparam logic [3:0] S_RM2   = 4'd5;
   localparam logic [3:0] S_RM3   = 4'd6;
   localparam logic [3:0] S_SETUP = 4'd7;
   localparam logic [3:0] S_BS    = 4'd8;
   localparam logic [3:0] S_BC    = 4'd9;
   localparam logic [3:0] S_SH    = 4'd10;
   localparam logic [3:0] S_SW    = 4'd11;
   localparam logic [3:0] S_MK    = 4'd12;
   localparam logic [3:0] S_MK2   = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   localparam int W  = bitr_pkg::WORD_W;
   localparam int PW = bitr_pkg::POS_W;
   localparam logic [W-1:0] MARK_END  = W'(bitr_pkg::MAX_READS);
   localparam logic [W-1:0] MARK_SIZE = W'(bitr_pkg::MAX_READS + 1);
   localparam logic signed [PW-1:0] SLOTS_POS = PW'(bitr_pkg::ID_SLOTS);

   // memories
   logic [W-1:0]                    id_mem   [bitr_pkg::ID_SLOTS];
   logic [bitr_pkg::START_W-1:0]    st_mem   [bitr_pkg::BIN_COUNT+1];
   logic                            flag_mem [bitr_pkg::BIN_COUNT];

   logic [3:0] state_ff, state_in;
   bitr_pkg::req_data_type item_ff, item_in;
   logic signed [PW-1:0] first_ff, first_in, limit_ff, limit_in, end_ff, end_in;
   logic signed [PW-1:0] size_ff, size_in, lo_ff, lo_in, count_ff, count_in;
   logic signed [PW-1:0] half_ff, half_in, probe_ff, probe_in, idx_ff, idx_in;
   logic signed [PW-1:0] stop_ff, stop_in;
   logic [W-1:0] m1_ff, m1_in, m2_ff, m2_in;
   logic phase_ff, phase_in, empty_ff, empty_in;
   logic [bitr_pkg::FLAG_AW-1:0] clr_ff, clr_in;
   logic ov_ff, ov_in;
   bitr_pkg::rsp_data_type out_ff, out_in;

   // memory ports
   logic                         id_re, id_we, rdv_ff;
   logic signed [PW-1:0]         id_ra, id_wa;
   logic [W-1:0]                 id_wd, id_rd_ff;
   logic                         st_we;
   logic [bitr_pkg::BIN_W-1:0]   st_ra, st_wa;
   logic [bitr_pkg::START_W-1:0] st_wd, st_rd_ff;
   logic                         flag_we, flag_wd, flag_rd_ff;
   logic [bitr_pkg::FLAG_AW-1:0] flag_ra, flag_wa;

   logic accept, out_free;
   logic [W-1:0] slot_data;
   logic signed [PW-1:0] end_m1;

   assign out_free = !ov_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = ov_ff;
   assign rsp_chan.data = out_ff;
   // slots outside the memory read as zero
   assign slot_data = rdv_ff ? id_rd_ff : '0;
   assign end_m1 = end_ff - PW'(1);

   // id memory, one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (id_we && id_wa >= 0 && id_wa < SLOTS_POS) begin
         id_mem[id_wa[bitr_pkg::SLOT_W-1:0]] <= id_wd;
      end
      if (id_re) begin
         id_rd_ff <= id_mem[id_ra[bitr_pkg::SLOT_W-1:0]];
      end
      rdv_ff <= id_re && id_ra >= 0 && id_ra < SLOTS_POS;
   end

   // bin start table
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_wa] <= st_wd;
      end
      st_rd_ff <= st_mem[st_ra];
   end

   // empty flags
   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      flag_rd_ff <= flag_mem[flag_ra];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      first_in = first_ff;
      limit_in = limit_ff;
      end_in   = end_ff;
      size_in  = size_ff;
      lo_in    = lo_ff;
      count_in = count_ff;
      half_in  = half_ff;
      probe_in = probe_ff;
      idx_in   = idx_ff;
      stop_in  = stop_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      phase_in = phase_ff;
      empty_in = empty_ff;
      clr_in   = clr_ff;
      ov_in    = ov_ff && !rsp_chan.ready;
      out_in   = out_ff;
      id_re    = 1'b0;
      id_ra    = '0;
      id_we    = 1'b0;
      id_wa    = '0;
      id_wd    = '0;
      st_we    = 1'b0;
      st_wa    = item_ff.bin_index;
      st_wd    = '0;
      st_ra    = item_ff.bin_index;
      flag_we  = 1'b0;
      flag_wa  = item_ff.bin_index[bitr_pkg::FLAG_AW-1:0];
      flag_wd  = 1'b0;
      flag_ra  = item_ff.bin_index[bitr_pkg::FLAG_AW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            flag_we = 1'b1;
            flag_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               item_in  = req_chan.data;
               phase_in = 1'b0;
               unique case (req_chan.data.opcode)
                  bitr_pkg::OP_LOAD_START: begin
                     st_we = req_chan.data.bin_index <=
                             bitr_pkg::BIN_W'(bitr_pkg::BIN_COUNT);
                     st_wa = req_chan.data.bin_index;
                     st_wd = req_chan.data.load_value[bitr_pkg::START_W-1:0];
                     out_in = '0;
                     ov_in  = 1'b1;
                  end
                  bitr_pkg::OP_LOAD_SLOT: begin
                     id_we  = 1'b1;
                     id_wa  = PW'(req_chan.data.slot_address);
                     id_wd  = req_chan.data.load_value;
                     out_in = '0;
                     ov_in  = 1'b1;
                  end
                  bitr_pkg::OP_FIND, bitr_pkg::OP_REMOVE: begin
                     if (req_chan.data.bin_index >=
                         bitr_pkg::BIN_W'(bitr_pkg::BIN_COUNT)) begin
                        out_in = '0;
                        ov_in  = 1'b1;
                     end else begin
                        state_in = S_FIRST;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FIRST: begin
            st_ra   = item_ff.bin_index;
            state_in = S_LIMIT;
         end
         S_LIMIT: begin
            first_in = PW'(st_rd_ff);
            empty_in = flag_rd_ff;
            st_ra    = item_ff.bin_index + 1'b1;
            state_in = S_RM1;
         end
         S_RM1: begin
            if (!phase_ff) begin
               limit_in = PW'(st_rd_ff);
               id_ra    = PW'(st_rd_ff) - PW'(1);
            end else begin
               id_ra    = limit_ff - PW'(1);
            end
            id_re    = 1'b1;
            state_in = S_RM2;
         end
         S_RM2: begin
            m1_in    = slot_data;
            id_re    = 1'b1;
            id_ra    = limit_ff - PW'(2);
            state_in = S_RM3;
         end
         S_RM3: begin
            m2_in = slot_data;
            if (phase_ff) begin
               state_in = S_MK;
            end else begin
               // logical end from the tail markers
               priority if (m1_ff == MARK_END) begin
                  end_in = limit_ff - PW'(1);
               end else if (m1_ff == MARK_SIZE) begin
                  end_in = first_ff + PW'(slot_data);
               end else begin
                  end_in = limit_ff;
               end
               state_in = (item_ff.opcode == bitr_pkg::OP_FIND) ? S_DONE : S_SETUP;
            end
         end
         S_SETUP: begin
            size_in  = end_ff - first_ff;
            lo_in    = first_ff;
            count_in = end_ff - first_ff;
            if (end_ff - first_ff == PW'(1)) begin
               flag_we  = 1'b1;
               flag_wd  = 1'b1;
               empty_in = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_BS;
            end
         end
         // lower-bound bisection, one probe read per step
         S_BS: begin
            if (count_ff > 0) begin
               half_in  = count_ff >>> 1;
               probe_in = lo_ff + (count_ff >>> 1);
               id_re    = 1'b1;
               id_ra    = lo_ff + (count_ff >>> 1);
               state_in = S_BC;
            end else begin
               idx_in   = lo_ff;
               stop_in  = (end_m1 > SLOTS_POS) ? SLOTS_POS : end_m1;
               state_in = S_SH;
            end
         end
         S_BC: begin
            if (slot_data < W'(item_ff.remove_id)) begin
               lo_in    = probe_ff + PW'(1);
               count_in = count_ff - half_ff - PW'(1);
            end else begin
               count_in = half_ff;
            end
            state_in = S_BS;
         end
         // shift later entries down one slot
         S_SH: begin
            if (idx_ff < stop_ff) begin
               id_re    = 1'b1;
               id_ra    = idx_ff + PW'(1);
               state_in = S_SW;
            end else begin
               phase_in = 1'b1;
               state_in = S_RM1;
            end
         end
         S_SW: begin
            id_we    = 1'b1;
            id_wa    = idx_ff;
            id_wd    = slot_data;
            idx_in   = idx_ff + PW'(1);
            state_in = S_SH;
         end
         // marker update
         S_MK: begin
            id_we = 1'b1;
            priority if (end_ff == limit_ff) begin
               id_wa    = limit_ff - PW'(1);
               id_wd    = MARK_END;
               state_in = S_DONE;
            end else if (m1_ff == MARK_END) begin
               id_wa    = limit_ff - PW'(1);
               id_wd    = MARK_SIZE;
               state_in = S_MK2;
            end else begin
               id_wa    = limit_ff - PW'(2);
               id_wd    = m2_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_MK2: begin
            id_we    = 1'b1;
            id_wa    = limit_ff - PW'(2);
            id_wd    = W'(size_ff - PW'(1));
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_in.range_begin = first_ff[bitr_pkg::START_W-1:0];
               out_in.range_end   = end_ff[bitr_pkg::START_W-1:0];
               out_in.bin_empty   = empty_ff;
               ov_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         ov_ff    <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ov_ff    <= ov_in;
         phase_ff <= phase_in;
      end
      item_ff  <= item_in;
      first_ff <= first_in;
      limit_ff <= limit_in;
      end_ff   <= end_in;
      size_ff  <= size_in;
      lo_ff    <= lo_in;
      count_ff <= count_in;
      half_ff  <= half_in;
      probe_ff <= probe_in;
      idx_ff   <= idx_in;
      stop_ff  <= stop_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      empty_ff <= empty_in;
      out_ff   <= out_in;
   end

endmodule

### hw/rtl/bitr_checker.sv
// Port-level checks of binned_id_table_remove, attached by bind.
// Depends on bitr_pkg and binned_id_table_remove_macros.svh.
`include "binned_id_table_remove_macros.svh"

module bitr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [bitr_pkg::OP_W-1:0] req_opcode,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input bitr_pkg::rsp_data_type rsp_data
);

   logic rsp_stall;
   logic load_acc;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign load_acc  = req_valid && req_ready &&
                      (req_opcode == bitr_pkg::OP_LOAD_START ||
                       req_opcode == bitr_pkg::OP_LOAD_SLOT);

   // stalled response item stays offered
   `BITR_ASSERT_NEXT(rsp_hold, rsp_stall, rsp_valid, "rsp item dropped")
   // no new item while a result is stuck
   `BITR_ASSERT_NOW(no_accept_on_stall, rsp_stall, !req_ready, "accept under stall")
   // load items answer in the next cycle with zero fields
   `BITR_ASSERT_NEXT(load_zero, load_acc, rsp_valid && rsp_data == '0, "load result wrong")
   // reset empties the output and holds off input
   `BITR_ASSERT_RST(reset_clear, reset, !rsp_valid && !req_ready, "reset state wrong")

endmodule

bind binned_id_table_remove bitr_checker u_bitr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_opcode (req_chan.data.opcode),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_data   (rsp_chan.data)
);
